FILE: hdl/gff_pkg.sv
package gff_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam logic [15:0] COST_NONE     = 16'hFFFF;
   localparam logic [15:0] COST_TOP      = 16'hFFFE;
   localparam logic [4:0]  STEP_STRAIGHT = 5'd10;
   localparam logic [4:0]  STEP_DIAG     = 5'd14;

   localparam logic [1:0] MODE_SET     = 2'd0;
   localparam logic [1:0] MODE_COMPUTE = 2'd1;
   localparam logic [1:0] MODE_QUERY   = 2'd2;
   localparam logic [1:0] MODE_CLEAR   = 2'd3;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GOAL_X = 2'd2;
   localparam logic [1:0] CSR_GOAL_Y = 2'd3;

   localparam logic [3:0] DIR_NONE = 4'd0;

   // Neighbor order is N E S W NE SE SW NW.
   function automatic logic signed [1:0] dir_dx(input logic [2:0] k);
      logic signed [1:0] r;
      case (k)
         3'd0: r = 2'sd0;
         3'd1: r = 2'sd1;
         3'd2: r = 2'sd0;
         3'd3: r = -2'sd1;
         3'd4: r = 2'sd1;
         3'd5: r = 2'sd1;
         3'd6: r = -2'sd1;
         3'd7: r = -2'sd1;
         default: r = 2'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [1:0] dir_dy(input logic [2:0] k);
      logic signed [1:0] r;
      case (k)
         3'd0: r = -2'sd1;
         3'd1: r = 2'sd0;
         3'd2: r = 2'sd1;
         3'd3: r = 2'sd0;
         3'd4: r = -2'sd1;
         3'd5: r = 2'sd1;
         3'd6: r = 2'sd1;
         3'd7: r = -2'sd1;
         default: r = 2'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hdl/grid_flow_field.sv
// Octile flow field over a grid of blocked cells.
// Words arrive on req_ with the command in req_tuser; only queries give a word on rsp_.
// Configuration must be written through csr_ while the block is idle (not enforced).
// A set command writes the blocked bit of a cell inside the grid on acceptance.
// A query's cell is read on acceptance, and S_QRD registers the result once the
// output register is free. A clear command sweeps all MAX_WIDTH*MAX_HEIGHT cells,
// one per cycle. A compute command runs the sweep keeping blocked bits; if the
// goal is inside the grid, a wavefront pass over the queued cells and their
// neighbors follows, then a direction pass over each reachable open cell's
// neighbors. Each cell store is a single memory; one adder forms all step costs.
// After reset the block runs the clearing sweep over all MAX_WIDTH*MAX_HEIGHT cells
// with req_tready low; configuration writes are taken throughout.
// A query result waits in the output register while rsp_tready is low; the block
// keeps taking other commands, and a second query holds until the first is taken.
module grid_flow_field #(
   parameter int MAX_WIDTH  = gff_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = gff_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // mode
   input  logic [15:0] req_tdata,  // cell_x, cell_y, blocked_bit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // reachable, path_cost, step_x, step_y
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata
);
   import gff_pkg::*;

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(CELLS);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int QW = XW + YW;

   typedef enum logic [3:0] {
      S_CLR, S_SEED, S_IDLE, S_QRD, S_POP, S_POPW, S_BASE, S_NB, S_NBCHK,
      S_DCELL, S_DCHK, S_DNB, S_DCMP, S_DWR
   } state_type;

   state_type state_ff;

   logic [6:0] grid_width_ff, grid_height_ff;
   logic [5:0] goal_x_ff, goal_y_ff;

   logic [AW-1:0] clr_ff;
   logic          clr_blk_ff, compute_ff, q_inside_ff;
   logic [XW-1:0] cur_x_ff, nb_x_ff;
   logic [YW-1:0] cur_y_ff, nb_y_ff;
   logic [2:0]    k_ff;
   logic [15:0]   base_ff, best_ff;
   logic [3:0]    pick_ff;
   logic [AW-1:0] head_ff, tail_ff;
   logic [AW:0]   count_ff;

   logic        rsp_valid_ff;
   logic        reach_ff;
   logic [15:0] cost_out_ff;
   logic [1:0]  step_x_ff, step_y_ff;

   logic          blk_mem [CELLS];
   logic [15:0]   cost_mem [CELLS];
   logic [3:0]    dir_mem [CELLS];
   logic          pend_mem [CELLS];
   logic [QW-1:0] queue_mem [CELLS];

   logic          blk_rd, pend_rd;
   logic [15:0]   cost_rd;
   logic [3:0]    dir_rd;
   logic [QW-1:0] q_rd;

   logic [AW-1:0] rd_addr, wr_addr;
   logic          blk_we, blk_wd, cost_we, pend_we, pend_wd, dir_we, q_we;
   logic [15:0]   cost_wd;
   logic [3:0]    dir_wd;
   logic [QW-1:0] q_wd;

   logic [WW-1:0] used_w;
   logic [HW-1:0] used_h;
   logic [5:0]    cell_x, cell_y;
   logic          in_range, goal_ok, nb_ok;
   logic [XW-1:0] cell_xi, goal_xi, nb_x;
   logic [YW-1:0] cell_yi, goal_yi, nb_y;
   logic [16:0]   sum;
   logic [15:0]   nc;
   int            nx, ny;

   function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
      return AW'(int'(y) * MAX_WIDTH + int'(x));
   endfunction

   assign used_w = (int'(grid_width_ff) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(grid_width_ff);
   assign used_h = (int'(grid_height_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(grid_height_ff);
   assign cell_x = req_tdata[5:0];
   assign cell_y = req_tdata[11:6];
   assign in_range = (int'(cell_x) < int'(used_w)) && (int'(cell_y) < int'(used_h));
   assign goal_ok = (int'(goal_x_ff) < int'(used_w)) && (int'(goal_y_ff) < int'(used_h));
   assign cell_xi = XW'(int'(cell_x));
   assign cell_yi = YW'(int'(cell_y));
   assign goal_xi = XW'(int'(goal_x_ff));
   assign goal_yi = YW'(int'(goal_y_ff));

   always_comb begin
      nx = int'(cur_x_ff) + int'(dir_dx(k_ff));
      ny = int'(cur_y_ff) + int'(dir_dy(k_ff));
      nb_ok = (nx >= 0) && (ny >= 0) && (nx < int'(used_w)) && (ny < int'(used_h));
      nb_x = XW'(nx);
      nb_y = YW'(ny);
   end

   assign sum = {1'b0, base_ff} + ((k_ff[2]) ? 17'(STEP_DIAG) : 17'(STEP_STRAIGHT));
   assign nc = (sum > 17'(COST_TOP)) ? COST_TOP : sum[15:0];

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      rd_addr = addr_of(cur_x_ff, cur_y_ff);
      wr_addr = clr_ff;
      blk_we = 1'b0;
      blk_wd = 1'b0;
      cost_we = 1'b0;
      cost_wd = COST_NONE;
      pend_we = 1'b0;
      pend_wd = 1'b0;
      dir_we = 1'b0;
      dir_wd = DIR_NONE;
      q_we = 1'b0;
      q_wd = {goal_yi, goal_xi};
      case (state_ff)
         S_CLR: begin
            blk_we = clr_blk_ff;
            cost_we = 1'b1;
            pend_we = 1'b1;
            dir_we = 1'b1;
         end
         S_SEED: begin
            wr_addr = addr_of(goal_xi, goal_yi);
            cost_we = 1'b1;
            cost_wd = 16'd0;
            pend_we = 1'b1;
            pend_wd = 1'b1;
            q_we = 1'b1;
         end
         S_IDLE: begin
            rd_addr = addr_of(cell_xi, cell_yi);
            wr_addr = addr_of(cell_xi, cell_yi);
            blk_wd = req_tdata[12];
            blk_we = req_tvalid && (req_tuser == MODE_SET) && in_range;
         end
         S_POPW: rd_addr = addr_of(q_rd[XW-1:0], q_rd[QW-1:XW]);
         S_BASE: begin
            wr_addr = addr_of(cur_x_ff, cur_y_ff);
            pend_we = 1'b1;
         end
         S_NB, S_DNB: rd_addr = addr_of(nb_x, nb_y);
         S_NBCHK: begin
            wr_addr = addr_of(nb_x_ff, nb_y_ff);
            q_wd = {nb_y_ff, nb_x_ff};
            cost_wd = nc;
            if (!blk_rd && nc < cost_rd) begin
               cost_we = 1'b1;
               pend_wd = 1'b1;
               pend_we = !pend_rd;
               q_we = !pend_rd;
            end
         end
         S_DWR: begin
            wr_addr = addr_of(cur_x_ff, cur_y_ff);
            dir_we = 1'b1;
            dir_wd = pick_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[wr_addr] <= blk_wd;
      end
      blk_rd <= blk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[wr_addr] <= cost_wd;
      end
      cost_rd <= cost_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[wr_addr] <= pend_wd;
      end
      pend_rd <= pend_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[wr_addr] <= dir_wd;
      end
      dir_rd <= dir_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[tail_ff] <= q_wd;
      end
      q_rd <= queue_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= 7'd64;
         grid_height_ff <= 7'd64;
         goal_x_ff <= 6'd0;
         goal_y_ff <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH: grid_width_ff <= csr_wdata;
            CSR_HEIGHT: grid_height_ff <= csr_wdata;
            CSR_GOAL_X: goal_x_ff <= csr_wdata[5:0];
            CSR_GOAL_Y: goal_y_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         clr_blk_ff <= 1'b1;
         compute_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         k_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               if (int'(clr_ff) == CELLS - 1) begin
                  clr_ff <= '0;
                  head_ff <= '0;
                  tail_ff <= '0;
                  count_ff <= '0;
                  state_ff <= (compute_ff && goal_ok) ? S_SEED : S_IDLE;
               end else begin
                  clr_ff <= clr_ff + 1'b1;
               end
            end
            S_SEED: begin
               tail_ff <= tail_ff + 1'b1;
               count_ff <= count_ff + 1'b1;
               state_ff <= S_POP;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  case (req_tuser)
                     MODE_COMPUTE: begin
                        clr_blk_ff <= 1'b0;
                        compute_ff <= 1'b1;
                        state_ff <= S_CLR;
                     end
                     MODE_CLEAR: begin
                        clr_blk_ff <= 1'b1;
                        compute_ff <= 1'b0;
                        state_ff <= S_CLR;
                     end
                     MODE_QUERY: begin
                        q_inside_ff <= in_range;
                        cur_x_ff <= cell_xi;
                        cur_y_ff <= cell_yi;
                        state_ff <= S_QRD;
                     end
                     default: ;
                  endcase
               end
            end
            S_QRD: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  reach_ff <= q_inside_ff && (cost_rd != COST_NONE);
                  cost_out_ff <= (q_inside_ff && cost_rd != COST_NONE) ? cost_rd : 16'd0;
                  if (q_inside_ff && dir_rd != DIR_NONE && dir_rd <= 4'd8) begin
                     step_x_ff <= dir_dx(3'(dir_rd - 4'd1));
                     step_y_ff <= dir_dy(3'(dir_rd - 4'd1));
                  end else begin
                     step_x_ff <= 2'd0;
                     step_y_ff <= 2'd0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_POP: begin
               if (count_ff == '0) begin
                  cur_x_ff <= '0;
                  cur_y_ff <= '0;
                  state_ff <= S_DCELL;
               end else begin
                  state_ff <= S_POPW;
               end
            end
            S_POPW: begin
               cur_x_ff <= q_rd[XW-1:0];
               cur_y_ff <= q_rd[QW-1:XW];
               state_ff <= S_BASE;
            end
            S_BASE: begin
               base_ff <= cost_rd;
               head_ff <= (int'(head_ff) == CELLS - 1) ? '0 : head_ff + 1'b1;
               count_ff <= count_ff - 1'b1;
               k_ff <= '0;
               state_ff <= S_NB;
            end
            S_NB: begin
               nb_x_ff <= nb_x;
               nb_y_ff <= nb_y;
               if (nb_ok) begin
                  state_ff <= S_NBCHK;
               end else if (k_ff == 3'd7) begin
                  state_ff <= S_POP;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_NBCHK: begin
               if (q_we) begin
                  tail_ff <= (int'(tail_ff) == CELLS - 1) ? '0 : tail_ff + 1'b1;
                  count_ff <= count_ff + 1'b1;
               end
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 3'd7) ? S_POP : S_NB;
            end
            S_DCELL: state_ff <= S_DCHK;
            S_DCHK: begin
               best_ff <= cost_rd;
               pick_ff <= DIR_NONE;
               k_ff <= '0;
               if (blk_rd || cost_rd == COST_NONE) begin
                  if (int'(cur_x_ff) + 1 == int'(used_w)) begin
                     cur_x_ff <= '0;
                     cur_y_ff <= cur_y_ff + 1'b1;
                     state_ff <= (int'(cur_y_ff) + 1 == int'(used_h)) ? S_IDLE : S_DCELL;
                  end else begin
                     cur_x_ff <= cur_x_ff + 1'b1;
                     state_ff <= S_DCELL;
                  end
               end else begin
                  state_ff <= S_DNB;
               end
            end
            S_DNB: begin
               if (nb_ok) begin
                  state_ff <= S_DCMP;
               end else if (k_ff == 3'd7) begin
                  state_ff <= S_DWR;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_DCMP: begin
               if (cost_rd < best_ff) begin
                  best_ff <= cost_rd;
                  pick_ff <= {1'b0, k_ff} + 4'd1;
               end
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 3'd7) ? S_DWR : S_DNB;
            end
            S_DWR: begin
               if (int'(cur_x_ff) + 1 == int'(used_w)) begin
                  cur_x_ff <= '0;
                  cur_y_ff <= cur_y_ff + 1'b1;
                  state_ff <= (int'(cur_y_ff) + 1 == int'(used_h)) ? S_IDLE : S_DCELL;
               end else begin
                  cur_x_ff <= cur_x_ff + 1'b1;
                  state_ff <= S_DCELL;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'd0, step_y_ff, step_x_ff, cost_out_ff, reach_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CELLS) else $error("work queue count beyond the cell count");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_QRD))
      else $error("response raised outside a query");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == MODE_COMPUTE) |=> !req_tready)
      else $error("compute accepted without a busy period");

   a_seed_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEED |-> count_ff == '0)
      else $error("seed with a non-empty work queue");

endmodule
